@@ hdl/lrbs_pkg.sv @@
// Package for the link reconnect backoff supervisor: widths, codes and beat types.
`default_nettype none
package lrbs_pkg;

	localparam int TIME_BITS    = 32;
	localparam int BACKOFF_BITS = 16;
	localparam int NEXT_BITS    = TIME_BITS + 1;
	localparam int FAIL_BITS    = 8;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DW       = 16;

	localparam logic [FAIL_BITS-1:0] FAIL_SAT = {FAIL_BITS{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_BACKOFF_MIN    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BACKOFF_MAX    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BACKOFF_MAX_SU = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_FAIL_ADVICE    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE         = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SILENT         = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_SEC_ENABLED    = 3'd6;

	// item kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_RESET = 1'b1;

	// connect outcomes
	localparam logic [1:0] OUT_REQUESTED = 2'd0;
	localparam logic [1:0] OUT_BUSY      = 2'd1;
	localparam logic [1:0] OUT_TRANSIENT = 2'd2;
	localparam logic [1:0] OUT_REFUSED   = 2'd3;

	// reason codes
	localparam logic [3:0] RSN_UNKNOWN    = 4'd0;
	localparam logic [3:0] RSN_UNPAIRED   = 4'd1;
	localparam logic [3:0] RSN_LOCAL_PROF = 4'd2;
	localparam logic [3:0] RSN_REFUSING   = 4'd3;
	localparam logic [3:0] RSN_PARTIAL    = 4'd4;
	localparam logic [3:0] RSN_CONNECTING = 4'd5;
	localparam logic [3:0] RSN_DISABLED   = 4'd6;
	localparam logic [3:0] RSN_NO_BEARER  = 4'd7;
	localparam logic [3:0] RSN_SILENT     = 4'd8;
	localparam logic [3:0] RSN_WAITING    = 4'd9;
	localparam logic [3:0] RSN_BOTH_UP    = 4'd10;
	localparam logic [3:0] RSN_NONE       = 4'd11;

	// status flag bit positions
	localparam int FL_PRESENT   = 0;
	localparam int FL_PAIRED    = 1;
	localparam int FL_PRIMARY   = 2;
	localparam int FL_SECONDARY = 3;
	localparam int FL_OFFERED   = 4;
	localparam int FL_DIALLING  = 5;
	localparam int FLAG_BITS    = 6;

	typedef struct packed {
		logic                 kind;
		logic [TIME_BITS-1:0] now;
		logic                 session_up;
		logic                 peer_present;
		logic                 peer_paired;
		logic                 primary_up;
		logic                 secondary_offered;
		logic                 secondary_up;
		logic [1:0]           connect_outcome;
		logic                 dial_pending_before;
		logic                 dial_pending_after;
	} item_t;

	typedef struct packed {
		logic                    changed;
		logic                    out_present;
		logic                    out_paired;
		logic                    out_primary_up;
		logic                    out_secondary_up;
		logic                    out_secondary_offered;
		logic                    out_dialling;
		logic [BACKOFF_BITS-1:0] retry_delay;
		logic [3:0]              reason_code;
		logic                    primary_attempt;
		logic                    secondary_attempt;
	} result_t;

endpackage
`default_nettype wire

@@ hdl/link_reconnect_backoff_supervisor.sv @@
// Top level of the link reconnect backoff supervisor.
//
// Tick and reset items arrive on the item channel (item_valid, item_stall,
// item); one result beat per item leaves on the result channel
// (result_valid, result_stall, result). An item is taken when valid is high
// and stall is low. The supervision state is updated in the cycle the item
// is taken and its result is registered in the output or skid register:
// one item per cycle while item_stall is low, set by the single update stage.
// Results sit in a two-entry output buffer: a stalled result beat holds in
// the output register while one more item is taken into the skid register;
// item_stall rises only while the skid register is full.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// is to use it only while the block is idle, which the block does not enforce.
// Reset (arst_n low) clears the status, counters, timestamps and backoff,
// sets the reason to none, loads the default configuration and empties the
// output buffer.
`default_nettype none
module link_reconnect_backoff_supervisor
	import lrbs_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0]       cfg_data,
	input  wire logic                    item_valid,
	output logic                         item_stall,
	input  wire item_t                   item,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output result_t                      result
);

	logic [BACKOFF_BITS-1:0] bmin_q, bmax_q, bmax_su_q;
	logic [FAIL_BITS-1:0]    fail_adv_q;
	logic [15:0]             settle_q, silent_q;
	logic                    sec_en_q;

	logic [FLAG_BITS-1:0]    flags_q, flags_n;
	logic [BACKOFF_BITS-1:0] backoff_q, backoff_n;
	logic [3:0]              reason_q, reason_n;
	logic [FAIL_BITS-1:0]    fail_q, fail_n;
	logic                    down_v_q, down_v_n, up_v_q, up_v_n;
	logic [TIME_BITS-1:0]    down_t_q, down_t_n, up_t_q, up_t_n;
	logic [NEXT_BITS-1:0]    next_q, next_n;
	logic                    spent_q, spent_n;

	result_t res_n, main_q, skid_q;
	logic    main_v_q, skid_v_q;
	logic    take_in, take_out;

	logic                    present, paired, prim, offered, sec, prev_sec;
	logic                    pa, sa, refused, settled, silent;
	logic [BACKOFF_BITS-1:0] ceiling, b1, grown;
	logic [NEXT_BITS-1:0]    n1;
	logic [FAIL_BITS-1:0]    c1, c_inc;
	logic [BACKOFF_BITS:0]   dbl;

	function automatic logic elapsed(input logic [TIME_BITS-1:0] t_now,
			input logic [TIME_BITS-1:0] since, input logic [15:0] span);
		logic [TIME_BITS-1:0] diff;
		diff = t_now - since;
		return (t_now >= since) && (diff >= {{(TIME_BITS-16){1'b0}}, span});
	endfunction

	assign item_stall   = skid_v_q;
	assign take_in      = item_valid && !skid_v_q;
	assign result_valid = main_v_q;
	assign result       = main_q;
	assign take_out     = main_v_q && !result_stall;

	always_comb begin
		flags_n   = flags_q;
		backoff_n = backoff_q;
		reason_n  = reason_q;
		fail_n    = fail_q;
		down_v_n  = down_v_q;
		down_t_n  = down_t_q;
		up_v_n    = up_v_q;
		up_t_n    = up_t_q;
		next_n    = next_q;
		spent_n   = spent_q;
		pa        = 1'b0;
		sa        = 1'b0;
		present   = item.peer_present;
		paired    = item.peer_present && item.peer_paired;
		prim      = item.primary_up;
		offered   = item.secondary_offered;
		sec       = item.secondary_offered && item.secondary_up;
		prev_sec  = flags_q[FL_SECONDARY];
		ceiling   = sec ? bmax_su_q : bmax_q;
		b1        = backoff_q;
		n1        = next_q;
		c1        = fail_q;
		dbl       = '0;
		grown     = '0;
		c_inc     = '0;
		refused   = 1'b0;
		settled   = 1'b0;
		silent    = 1'b0;

		if (item.kind == KIND_RESET) begin
			fail_n    = '0;
			down_v_n  = 1'b0;
			down_t_n  = '0;
			up_v_n    = 1'b0;
			up_t_n    = '0;
			next_n    = '0;
			backoff_n = '0;
		end else begin
			flags_n = '0;
			flags_n[FL_DIALLING] = flags_q[FL_DIALLING];
			flags_n[FL_PRESENT]  = present;
			flags_n[FL_PAIRED]   = paired;
			if (!paired) begin
				up_v_n   = 1'b0;
				reason_n = present ? RSN_UNPAIRED : RSN_UNKNOWN;
			end else begin
				flags_n[FL_PRIMARY]   = prim;
				flags_n[FL_OFFERED]   = offered;
				flags_n[FL_SECONDARY] = sec;
				if (sec) begin
					down_v_n = 1'b0;
					flags_n[FL_DIALLING] = 1'b0;
				end else if (!down_v_q) begin
					down_v_n = 1'b1;
					down_t_n = item.now;
				end
				if (sec && !prev_sec) begin
					b1 = '0;
					n1 = '0;
					c1 = '0;
				end
				backoff_n = b1;
				next_n    = n1;
				fail_n    = c1;

				dbl   = {b1, 1'b0};
				if (b1 == '0) begin
					grown = bmin_q;
				end else if (dbl > {1'b0, ceiling}) begin
					grown = ceiling;
				end else begin
					grown = dbl[BACKOFF_BITS-1:0];
				end
				c_inc = (c1 == FAIL_SAT) ? c1 : c1 + 1'b1;

				if (!prim) begin
					up_v_n = 1'b0;
					if ({1'b0, item.now} >= n1) begin
						pa = 1'b1;
						case (item.connect_outcome)
							OUT_REQUESTED: begin
								backoff_n = '0;
								fail_n    = '0;
							end
							OUT_BUSY: begin
								backoff_n = grown;
							end
							OUT_TRANSIENT: begin
								fail_n    = c_inc;
								backoff_n = bmin_q;
							end
							OUT_REFUSED: begin
								fail_n    = c_inc;
								backoff_n = grown;
							end
							default: begin
								backoff_n = '0;
							end
						endcase
						if (item.connect_outcome == OUT_REQUESTED) begin
							next_n = '0;
						end else begin
							next_n = {1'b0, item.now}
								+ {{(NEXT_BITS-BACKOFF_BITS){1'b0}}, backoff_n};
						end
					end
					refused = fail_n >= fail_adv_q;
					if (refused && item.session_up) begin
						reason_n = RSN_LOCAL_PROF;
					end else if (refused && !sec) begin
						reason_n = RSN_REFUSING;
					end else if (sec) begin
						reason_n = RSN_PARTIAL;
					end else begin
						reason_n = RSN_CONNECTING;
					end
				end else begin
					if (!up_v_q) begin
						up_v_n = 1'b1;
						up_t_n = item.now;
					end
					backoff_n = '0;
					fail_n    = '0;
					if (!sec_en_q) begin
						reason_n = RSN_DISABLED;
					end else if (!offered) begin
						reason_n = RSN_NO_BEARER;
					end else if (!sec) begin
						settled = elapsed(item.now, up_t_n, settle_q);
						if (!spent_q && settled && !item.dial_pending_before) begin
							sa      = 1'b1;
							spent_n = 1'b1;
						end
						flags_n[FL_DIALLING] = item.dial_pending_after;
						silent = down_v_n && elapsed(item.now, down_t_n, silent_q);
						reason_n = silent ? RSN_SILENT : RSN_WAITING;
					end else begin
						reason_n = RSN_BOTH_UP;
					end
				end
			end
		end

		res_n.changed = (item.kind == KIND_TICK) && ((flags_n != flags_q)
			|| (backoff_n != backoff_q) || (reason_n != reason_q));
		res_n.out_present           = flags_n[FL_PRESENT];
		res_n.out_paired            = flags_n[FL_PAIRED];
		res_n.out_primary_up        = flags_n[FL_PRIMARY];
		res_n.out_secondary_up      = flags_n[FL_SECONDARY];
		res_n.out_secondary_offered = flags_n[FL_OFFERED];
		res_n.out_dialling          = flags_n[FL_DIALLING];
		res_n.retry_delay           = backoff_n;
		res_n.reason_code           = reason_n;
		res_n.primary_attempt       = pa;
		res_n.secondary_attempt     = sa;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bmin_q     <= 16'd2;
			bmax_q     <= 16'd300;
			bmax_su_q  <= 16'd60;
			fail_adv_q <= 8'd3;
			settle_q   <= 16'd5;
			silent_q   <= 16'd30;
			sec_en_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BACKOFF_MIN:    bmin_q     <= cfg_data;
				REG_BACKOFF_MAX:    bmax_q     <= cfg_data;
				REG_BACKOFF_MAX_SU: bmax_su_q  <= cfg_data;
				REG_FAIL_ADVICE:    fail_adv_q <= cfg_data[FAIL_BITS-1:0];
				REG_SETTLE:         settle_q   <= cfg_data;
				REG_SILENT:         silent_q   <= cfg_data;
				REG_SEC_ENABLED:    sec_en_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= '0;
			backoff_q <= '0;
			reason_q  <= RSN_NONE;
			fail_q    <= '0;
			down_v_q  <= 1'b0;
			down_t_q  <= '0;
			up_v_q    <= 1'b0;
			up_t_q    <= '0;
			next_q    <= '0;
			spent_q   <= 1'b0;
		end else if (take_in) begin
			flags_q   <= flags_n;
			backoff_q <= backoff_n;
			reason_q  <= reason_n;
			fail_q    <= fail_n;
			down_v_q  <= down_v_n;
			down_t_q  <= down_t_n;
			up_v_q    <= up_v_n;
			up_t_q    <= up_t_n;
			next_q    <= next_n;
			spent_q   <= spent_n;
		end
	end

	// result buffer: output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take_out) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= take_in;
			end
		end else if (take_in) begin
			if (main_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (take_in) begin
				main_q <= res_n;
			end
		end else if (take_in) begin
			if (main_v_q) begin
				skid_q <= res_n;
			end else begin
				main_q <= res_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for the link reconnect backoff supervisor: directed and random ticks checked against a predictor.
module tb_top;
	import lrbs_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DW-1:0]       cfg_data = '0;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	item_t                   in_beat = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	result_t                 out_beat;

	link_reconnect_backoff_supervisor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (in_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (out_beat)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	// supervisor copy: configuration
	logic [BACKOFF_BITS-1:0] cf_min = 16'd2;
	logic [BACKOFF_BITS-1:0] cf_max = 16'd300;
	logic [BACKOFF_BITS-1:0] cf_max_su = 16'd60;
	logic [FAIL_BITS-1:0]    cf_advice = 8'd3;
	logic [15:0]             cf_settle = 16'd5;
	logic [15:0]             cf_silent = 16'd30;
	logic                    cf_sec_en = 1'b1;

	// supervisor copy: state
	logic [FLAG_BITS-1:0]    st_flags = '0;
	logic [BACKOFF_BITS-1:0] st_backoff = '0;
	logic [3:0]              st_reason = RSN_NONE;
	logic [FAIL_BITS-1:0]    st_fails = '0;
	logic                    st_down_ok = 1'b0;
	logic [TIME_BITS-1:0]    st_down_t = '0;
	logic                    st_up_ok = 1'b0;
	logic [TIME_BITS-1:0]    st_up_t = '0;
	logic [NEXT_BITS-1:0]    st_next = '0;
	logic                    st_dial_done = 1'b0;

	result_t predicted_results[$];
	int      mismatches = 0;
	int      items_taken = 0;
	int      beats_checked = 0;
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      holdoff_cycles = 0;

	// stimulus generator state
	logic [TIME_BITS-1:0] sim_now = '0;
	logic lk_present = 1'b1, lk_paired = 1'b1, lk_prim = 1'b0;
	logic lk_offered = 1'b1, lk_sec = 1'b0;
	logic steady_mode = 1'b0;

	function automatic logic [BACKOFF_BITS-1:0] grown_backoff(
		input logic [BACKOFF_BITS-1:0] ceil_v);
		logic [BACKOFF_BITS:0] v;
		if (st_backoff == '0)
			return cf_min;
		v = {st_backoff, 1'b0};
		if (v > {1'b0, ceil_v})
			v = {1'b0, ceil_v};
		return v[BACKOFF_BITS-1:0];
	endfunction

	function automatic logic [NEXT_BITS-1:0] retry_at(input logic [TIME_BITS-1:0] now_s);
		logic [NEXT_BITS:0] sum;
		sum = {2'b00, now_s} + {{(NEXT_BITS+1-BACKOFF_BITS){1'b0}}, st_backoff};
		if (sum > {1'b0, {NEXT_BITS{1'b1}}})
			sum = {1'b0, {NEXT_BITS{1'b1}}};
		return sum[NEXT_BITS-1:0];
	endfunction

	function automatic logic span_passed(input logic [TIME_BITS-1:0] now_s,
		input logic [TIME_BITS-1:0] since, input logic [15:0] span);
		return (now_s >= since) && ((now_s - since) >= {{(TIME_BITS-16){1'b0}}, span});
	endfunction

	function automatic result_t supervise_tick(input item_t it);
		result_t r;
		logic [FLAG_BITS-1:0] f, pf;
		logic [BACKOFF_BITS-1:0] pb, ceil_v;
		logic [3:0] pr;
		logic paired, sec, prev_sec, refused, pa, sa;
		logic [NEXT_BITS-1:0] now_n;
		r = '0;
		pf = st_flags;
		pb = st_backoff;
		pr = st_reason;
		pa = 1'b0;
		sa = 1'b0;
		now_n = {1'b0, it.now};
		if (it.kind == KIND_RESET) begin
			st_fails = '0;
			st_down_ok = 1'b0;
			st_down_t = '0;
			st_up_ok = 1'b0;
			st_up_t = '0;
			st_next = '0;
			st_backoff = '0;
		end else begin
			paired = it.peer_present & it.peer_paired;
			sec = it.secondary_offered & it.secondary_up;
			prev_sec = st_flags[FL_SECONDARY];
			f = '0;
			f[FL_DIALLING] = st_flags[FL_DIALLING];
			f[FL_PRESENT] = it.peer_present;
			f[FL_PAIRED] = paired;
			if (!paired) begin
				st_up_ok = 1'b0;
				st_reason = it.peer_present ? RSN_UNPAIRED : RSN_UNKNOWN;
			end else begin
				f[FL_PRIMARY] = it.primary_up;
				f[FL_OFFERED] = it.secondary_offered;
				f[FL_SECONDARY] = sec;
				if (sec)
					st_down_ok = 1'b0;
				else if (!st_down_ok) begin
					st_down_ok = 1'b1;
					st_down_t = it.now;
				end
				if (sec)
					f[FL_DIALLING] = 1'b0;
				if (sec && !prev_sec) begin
					st_backoff = '0;
					st_next = '0;
					st_fails = '0;
				end
				if (!it.primary_up) begin
					ceil_v = sec ? cf_max_su : cf_max;
					st_up_ok = 1'b0;
					if (now_n >= st_next) begin
						pa = 1'b1;
						case (it.connect_outcome)
							OUT_REQUESTED: begin
								st_backoff = '0;
								st_next = '0;
								st_fails = '0;
							end
							OUT_BUSY: begin
								st_backoff = grown_backoff(ceil_v);
								st_next = retry_at(it.now);
							end
							OUT_TRANSIENT: begin
								if (st_fails != FAIL_SAT)
									st_fails++;
								st_backoff = cf_min;
								st_next = retry_at(it.now);
							end
							default: begin
								if (st_fails != FAIL_SAT)
									st_fails++;
								st_backoff = grown_backoff(ceil_v);
								st_next = retry_at(it.now);
							end
						endcase
					end
					refused = st_fails >= cf_advice;
					if (refused && it.session_up)
						st_reason = RSN_LOCAL_PROF;
					else if (refused && !sec)
						st_reason = RSN_REFUSING;
					else if (sec)
						st_reason = RSN_PARTIAL;
					else
						st_reason = RSN_CONNECTING;
				end else begin
					if (!st_up_ok) begin
						st_up_ok = 1'b1;
						st_up_t = it.now;
					end
					st_backoff = '0;
					st_fails = '0;
					if (!cf_sec_en)
						st_reason = RSN_DISABLED;
					else if (!it.secondary_offered)
						st_reason = RSN_NO_BEARER;
					else if (!sec) begin
						if (!st_dial_done && span_passed(it.now, st_up_t, cf_settle)
							&& !it.dial_pending_before) begin
							sa = 1'b1;
							st_dial_done = 1'b1;
						end
						f[FL_DIALLING] = it.dial_pending_after;
						st_reason = (st_down_ok && span_passed(it.now, st_down_t, cf_silent))
							? RSN_SILENT : RSN_WAITING;
					end else
						st_reason = RSN_BOTH_UP;
				end
			end
			st_flags = f;
			r.changed = (pf != st_flags) || (pb != st_backoff) || (pr != st_reason);
		end
		r.out_present = st_flags[FL_PRESENT];
		r.out_paired = st_flags[FL_PAIRED];
		r.out_primary_up = st_flags[FL_PRIMARY];
		r.out_secondary_up = st_flags[FL_SECONDARY];
		r.out_secondary_offered = st_flags[FL_OFFERED];
		r.out_dialling = st_flags[FL_DIALLING];
		r.retry_delay = st_backoff;
		r.reason_code = st_reason;
		r.primary_attempt = pa;
		r.secondary_attempt = sa;
		return r;
	endfunction

	function automatic void load_register(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DW-1:0] v);
		case (idx)
			REG_BACKOFF_MIN:    cf_min = v;
			REG_BACKOFF_MAX:    cf_max = v;
			REG_BACKOFF_MAX_SU: cf_max_su = v;
			REG_FAIL_ADVICE:    cf_advice = v[FAIL_BITS-1:0];
			REG_SETTLE:         cf_settle = v;
			REG_SILENT:         cf_silent = v;
			REG_SEC_ENABLED:    cf_sec_en = v[0];
			default: ;
		endcase
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (cfg_we)
				load_register(cfg_index, cfg_data);
			if (item_valid && !item_stall) begin
				predicted_results.push_back(supervise_tick(in_beat));
				items_taken++;
			end
			if (result_valid && !result_stall) begin
				beats_checked++;
				if (predicted_results.size() == 0) begin
					mismatches++;
					$display("%0t: result beat expected none actual %p", $time, out_beat);
				end else begin
					want = predicted_results.pop_front();
					compare_field("changed", 32'(want.changed), 32'(out_beat.changed));
					compare_field("out_present", 32'(want.out_present),
						32'(out_beat.out_present));
					compare_field("out_paired", 32'(want.out_paired),
						32'(out_beat.out_paired));
					compare_field("out_primary_up", 32'(want.out_primary_up),
						32'(out_beat.out_primary_up));
					compare_field("out_secondary_up", 32'(want.out_secondary_up),
						32'(out_beat.out_secondary_up));
					compare_field("out_secondary_offered", 32'(want.out_secondary_offered),
						32'(out_beat.out_secondary_offered));
					compare_field("out_dialling", 32'(want.out_dialling),
						32'(out_beat.out_dialling));
					compare_field("retry_delay", 32'(want.retry_delay),
						32'(out_beat.retry_delay));
					compare_field("reason_code", 32'(want.reason_code),
						32'(out_beat.reason_code));
					compare_field("primary_attempt", 32'(want.primary_attempt),
						32'(out_beat.primary_attempt));
					compare_field("secondary_attempt", 32'(want.secondary_attempt),
						32'(out_beat.secondary_attempt));
				end
			end
		end
	end

	// receiver: random stall, or a counted hold-off when one is requested
	initial begin
		forever begin
			@(negedge clk);
			if (holdoff_cycles > 0) begin
				result_stall = 1'b1;
				holdoff_cycles--;
			end else
				result_stall = ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_item(input item_t it);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		in_beat = it;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		@(negedge clk);
		item_valid = 1'b0;
		while (predicted_results.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DW-1:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_config(input logic [15:0] bmin, input logic [15:0] bmax,
		input logic [15:0] bmax_su, input logic [7:0] advice, input logic [15:0] settle,
		input logic [15:0] silent, input logic en);
		write_reg(REG_BACKOFF_MIN, bmin);
		write_reg(REG_BACKOFF_MAX, bmax);
		write_reg(REG_BACKOFF_MAX_SU, bmax_su);
		write_reg(REG_FAIL_ADVICE, {8'h00, advice});
		write_reg(REG_SETTLE, settle);
		write_reg(REG_SILENT, silent);
		write_reg(REG_SEC_ENABLED, {15'h0000, en});
	endtask

	task automatic set_idle(input int sender, input int receiver);
		idle_pct = sender;
		stall_pct = receiver;
	endtask

	function automatic item_t mk(input logic kind, input logic [31:0] now_s,
		input logic session, input logic present, input logic paired, input logic prim,
		input logic offered, input logic sec_up, input logic [1:0] outcome,
		input logic pend_b, input logic pend_a);
		item_t it;
		it.kind = kind;
		it.now = now_s;
		it.session_up = session;
		it.peer_present = present;
		it.peer_paired = paired;
		it.primary_up = prim;
		it.secondary_offered = offered;
		it.secondary_up = sec_up;
		it.connect_outcome = outcome;
		it.dial_pending_before = pend_b;
		it.dial_pending_after = pend_a;
		return it;
	endfunction

	function automatic logic drift(input logic cur, input int off_pct, input int on_pct);
		if (cur)
			return !($urandom_range(99) < off_pct);
		return $urandom_range(99) < on_pct;
	endfunction

	task automatic roll_item(output item_t it);
		int r;
		r = $urandom_range(99);
		if (steady_mode)
			sim_now += $urandom_range(1, 6);
		else if (r < 3)
			sim_now -= $urandom_range(1, 20);
		else if (r < 5)
			sim_now = $urandom();
		else if (r < 7)
			sim_now += $urandom_range(100, 70000);
		else
			sim_now += $urandom_range(0, 6);
		if (steady_mode) begin
			lk_present = 1'b1;
			lk_paired = 1'b1;
			lk_prim = 1'b0;
			lk_sec = 1'b0;
		end else begin
			lk_present = drift(lk_present, 3, 30);
			lk_paired = drift(lk_paired, 3, 30);
			lk_prim = drift(lk_prim, 10, 20);
			lk_offered = drift(lk_offered, 5, 20);
			lk_sec = drift(lk_sec, 10, 15);
		end
		it = mk((!steady_mode && $urandom_range(99) < 3) ? KIND_RESET : KIND_TICK, sim_now,
			$urandom_range(99) < 30, lk_present, lk_paired, lk_prim, lk_offered, lk_sec,
			steady_mode ? ($urandom_range(1) ? OUT_REFUSED : OUT_TRANSIENT)
				: 2'($urandom_range(3)),
			1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic run_random(input int n);
		item_t it;
		repeat (n) begin
			roll_item(it);
			send_item(it);
		end
	endtask

	task automatic test_directed();
		set_idle(0, 0);
		send_item(mk(KIND_TICK, 32'd0, 0, 0, 1, 0, 0, 0, OUT_REQUESTED, 0, 0));
		send_item(mk(KIND_TICK, 32'd1, 0, 1, 0, 0, 0, 0, OUT_REQUESTED, 0, 0));
		send_item(mk(KIND_TICK, 32'd2, 0, 1, 1, 0, 1, 0, OUT_BUSY, 0, 0));
		send_item(mk(KIND_TICK, 32'd3, 0, 1, 1, 0, 1, 0, OUT_REQUESTED, 0, 0));
		send_item(mk(KIND_TICK, 32'd4, 0, 1, 1, 0, 1, 0, OUT_BUSY, 0, 0));
		send_item(mk(KIND_TICK, 32'd8, 0, 1, 1, 0, 1, 0, OUT_REFUSED, 0, 0));
		send_item(mk(KIND_TICK, 32'd16, 0, 1, 1, 0, 1, 0, OUT_TRANSIENT, 0, 0));
		send_item(mk(KIND_TICK, 32'd18, 1, 1, 1, 0, 1, 0, OUT_REFUSED, 0, 0));
		send_item(mk(KIND_TICK, 32'd100, 0, 1, 1, 0, 1, 0, OUT_REFUSED, 0, 0));
		send_item(mk(KIND_TICK, 32'd50, 0, 1, 1, 0, 1, 0, OUT_REQUESTED, 0, 0));
		send_item(mk(KIND_TICK, 32'd200, 0, 1, 1, 0, 1, 0, OUT_REQUESTED, 0, 0));
		send_item(mk(KIND_TICK, 32'd200, 0, 1, 1, 1, 0, 0, OUT_REFUSED, 0, 0));
		send_item(mk(KIND_TICK, 32'd202, 0, 1, 1, 1, 1, 0, OUT_BUSY, 0, 1));
		send_item(mk(KIND_TICK, 32'd206, 0, 1, 1, 1, 1, 0, OUT_BUSY, 1, 1));
		send_item(mk(KIND_TICK, 32'd207, 0, 1, 1, 1, 1, 0, OUT_BUSY, 0, 1));
		send_item(mk(KIND_TICK, 32'd208, 0, 1, 1, 1, 1, 1, OUT_TRANSIENT, 0, 0));
		send_item(mk(KIND_TICK, 32'd210, 0, 1, 1, 0, 1, 1, OUT_REFUSED, 0, 0));
		send_item(mk(KIND_RESET, 32'd211, 0, 1, 1, 0, 1, 1, OUT_REFUSED, 0, 0));
		send_item(mk(KIND_TICK, 32'hFFFF_FFF0, 0, 1, 1, 0, 1, 0, OUT_BUSY, 0, 0));
		send_item(mk(KIND_TICK, 32'hFFFF_FFFF, 0, 1, 1, 0, 1, 0, OUT_REFUSED, 0, 0));
		send_item(mk(KIND_TICK, 32'd0, 0, 1, 1, 0, 1, 0, OUT_REQUESTED, 0, 0));
		send_item(mk(KIND_TICK, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1, OUT_REFUSED, 1, 1));
		send_item(mk(KIND_RESET, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1, OUT_REFUSED, 1, 1));
		drain();
	endtask

	task automatic test_low_extremes();
		set_config(16'hFFFF, 16'd1, 16'd1, 8'd0, 16'd0, 16'd0, 1'b0);
		set_idle(56, 0);
		run_random(200);
		drain();
	endtask

	task automatic test_high_extremes();
		set_config(16'd1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
		set_idle(0, 56);
		run_random(200);
		drain();
	endtask

	task automatic test_failure_saturation();
		set_config(16'd1, 16'd1, 16'd1, 8'hFF, 16'd3, 16'd10, 1'b1);
		set_idle(7, 7);
		steady_mode = 1'b1;
		run_random(320);
		steady_mode = 1'b0;
		drain();
	endtask

	task automatic test_random_settings();
		for (int round = 0; round < 4; round++) begin
			if (round == 0)
				set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
					16'($urandom_range(1, 65535)), 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					1'($urandom_range(1)));
			else
				set_config(16'($urandom_range(1, 8)), 16'($urandom_range(1, 400)),
					16'($urandom_range(1, 100)), 8'($urandom_range(0, 6)),
					16'($urandom_range(0, 20)), 16'($urandom_range(0, 60)),
					$urandom_range(99) < 75);
			case (round)
				0: set_idle(0, 0);
				1: set_idle(56, 0);
				2: set_idle(0, 56);
				default: set_idle(7, 7);
			endcase
			run_random(190);
			drain();
		end
	endtask

	task automatic test_receiver_holdoff();
		set_config(16'd2, 16'd300, 16'd60, 8'd3, 16'd5, 16'd30, 1'b1);
		set_idle(0, 0);
		@(posedge clk);
		holdoff_cycles = 80;
		run_random(60);
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_low_extremes();
		test_high_extremes();
		test_failure_saturation();
		test_random_settings();
		test_receiver_holdoff();
		if (predicted_results.size() != 0) begin
			mismatches += predicted_results.size();
			$display("%0t: %0d expected results never arrived", $time,
				predicted_results.size());
		end
		$display("%0d items taken, %0d result beats checked, %0d mismatches",
			items_taken, beats_checked, mismatches);
		$display("covered default, extreme and random settings, four idle mixes, one hold-off");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/lrbs_pkg.sv
hdl/link_reconnect_backoff_supervisor.sv
tb/sv/tb_top.sv
